// ----- src/psv_pkg.sv -----
// Shared types and constants for the PCM sample player voice.
// Holds the command, mode and register index codes and the reset values.
// No dependencies.
`default_nettype none

package psv_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned WADDR_W   = 16;
    localparam int unsigned VOL_W     = 17;
    localparam int unsigned LEN_W     = 17;
    localparam int unsigned BLKCFG_W  = 13;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 17;
    localparam int unsigned MODE_W    = 2;

    // Mid-scale code of an unsigned 8-bit sample.
    localparam logic [BYTE_W-1:0] MID_CODE = 8'd128;

    // Register reset values.
    localparam logic              RST_LOOP_ENABLE   = 1'b0;
    localparam logic [VOL_W-1:0]  RST_VOLUME        = 17'd65536;
    localparam logic [LEN_W-1:0]  RST_SAMPLE_LENGTH = 17'd0;
    localparam logic [BYTE_W-1:0] RST_SILENCE_LEVEL = 8'd128;
    localparam logic [BLKCFG_W-1:0] RST_BLOCK_LENGTH = 13'(1024 / 2);

    // Commands carried by an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_PLAY   = 3'd1,
        CMD_PAUSE  = 3'd2,
        CMD_RESUME = 3'd3,
        CMD_STOP   = 3'd4,
        CMD_WRITE  = 3'd5
    } t_cmd;

    // Player mode, reported as the voice state.
    typedef enum logic [MODE_W-1:0] {
        MODE_STOPPED = 2'd0,
        MODE_PLAYING = 2'd1,
        MODE_PAUSED  = 2'd2
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_ENABLE   = 3'd0,
        CFG_VOLUME        = 3'd1,
        CFG_SAMPLE_LENGTH = 3'd2,
        CFG_SILENCE_LEVEL = 3'd3,
        CFG_BLOCK_LENGTH  = 3'd4
    } t_cfg_idx;

endpackage

`default_nettype wire

// ----- src/psv_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the sample memory. No dependencies.
`default_nettype none

module psv_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; a read at the address being written returns the old byte.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/pcm_sample_player_voice.sv -----
// PCM sample player voice: 8-bit unsigned mono playback from a sample RAM.
// An accepted item passes through stage A (RAM read), then stage B (scaling into the result register).
// Throughput: one item per cycle while the output is not stalled; the sample RAM read port sets the two-stage depth.
// A sample write is held in a pending register before it reaches the RAM; a tick reading it meanwhile is forwarded.
// Reset (synchronous, active low) stops the voice, rewinds, restores register defaults
// and empties the pipeline; the sample RAM is not cleared.
`default_nettype none

module pcm_sample_player_voice #(
    parameter int unsigned SAMPLE_DEPTH = 65536,
    parameter int unsigned MAX_BLOCK    = 4096
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // Input items
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire  [psv_pkg::CMD_W-1:0]             i_cmd,
    input  wire  [psv_pkg::WADDR_W-1:0]           i_write_addr,
    input  wire  [psv_pkg::BYTE_W-1:0]            i_write_byte,
    // Result items
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic [psv_pkg::BYTE_W-1:0]            o_sample_out,
    output logic                                  o_sample_valid,
    output logic [psv_pkg::MODE_W-1:0]            o_voice_state,
    output logic                                  o_end_event,
    // Configuration writes
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [psv_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [psv_pkg::CFG_DAT_W-1:0]         i_cfg_data
);

    localparam int unsigned AW   = $clog2(SAMPLE_DEPTH);
    localparam int unsigned PH_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int unsigned BL_W = ($clog2(MAX_BLOCK + 1) > psv_pkg::BLKCFG_W) ?
                                   $clog2(MAX_BLOCK + 1) : psv_pkg::BLKCFG_W;
    localparam int unsigned LW   = psv_pkg::LEN_W;

    // Configuration registers.
    logic                            r_loop;
    logic [psv_pkg::VOL_W-1:0]       r_volume;
    logic [LW-1:0]                   r_length;
    logic [psv_pkg::BYTE_W-1:0]      r_silence;
    logic [psv_pkg::BLKCFG_W-1:0]    r_block_len;

    // Voice state.
    psv_pkg::t_mode                  r_mode, n_mode;
    logic [LW-1:0]                   r_pos, n_pos;
    logic [AW-1:0]                   r_rd_addr, n_rd_addr;
    logic [PH_W-1:0]                 r_phase, n_phase;

    // Pending sample write.
    logic                            r_w_valid;
    logic [psv_pkg::WADDR_W-1:0]     r_w_addr_raw;
    logic [psv_pkg::BYTE_W-1:0]      r_w_byte;
    logic [AW-1:0]                   w_addr;

    // Stage A (alongside the RAM read data) and stage B (result register).
    logic                            r_a_valid;
    logic                            r_a_play;
    logic                            r_a_fwd;
    logic [psv_pkg::BYTE_W-1:0]      r_a_fwd_byte;
    logic [psv_pkg::BYTE_W-1:0]      r_a_base;
    logic                            r_a_svalid;
    psv_pkg::t_mode                  r_a_mode;
    logic                            r_a_end;
    logic                            r_b_valid;
    logic [psv_pkg::BYTE_W-1:0]      r_b_sample;
    logic                            r_b_svalid;
    psv_pkg::t_mode                  r_b_mode;
    logic                            r_b_end;

    logic                            in_accept;
    logic                            advance;
    psv_pkg::t_cmd                   cmd;
    logic [psv_pkg::BYTE_W-1:0]      ram_q;

    // Tick decode signals.
    logic [BL_W-1:0]                 blen_ext;
    logic [BL_W-1:0]                 blen_eff;
    logic [BL_W-1:0]                 phase_inc;
    logic [PH_W-1:0]                 phase_next;
    logic                            at_end;
    logic                            stop_now;
    logic [LW-1:0]                   pos1;
    logic [AW-1:0]                   addr1;
    logic [AW-1:0]                   addr_inc;
    logic                            have_data;
    logic                            rd_en;
    logic                            fwd_hit;

    // Result of the item being accepted.
    logic [psv_pkg::BYTE_W-1:0]      res_base;
    logic                            res_svalid;
    logic                            res_end;
    logic                            res_play;

    // Scaling of the sample read back.
    logic [psv_pkg::BYTE_W-1:0]      smp_byte;
    logic signed [9:0]               smp_diff;
    logic signed [9:0]               vol_gain;
    logic signed [19:0]              product;
    logic [psv_pkg::BYTE_W-1:0]      scaled;

    // Handshakes: stage A moves on when the result register is free or being taken.
    assign advance     = !r_b_valid || !i_stall;
    assign o_stall     = r_a_valid && !advance;
    assign in_accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign cmd         = psv_pkg::t_cmd'(i_cmd);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop      <= psv_pkg::RST_LOOP_ENABLE;
            r_volume    <= psv_pkg::RST_VOLUME;
            r_length    <= psv_pkg::RST_SAMPLE_LENGTH;
            r_silence   <= psv_pkg::RST_SILENCE_LEVEL;
            r_block_len <= psv_pkg::RST_BLOCK_LENGTH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (psv_pkg::t_cfg_idx'(i_cfg_index))
                psv_pkg::CFG_LOOP_ENABLE:   r_loop      <= i_cfg_data[0];
                psv_pkg::CFG_VOLUME:        r_volume    <= i_cfg_data[psv_pkg::VOL_W-1:0];
                psv_pkg::CFG_SAMPLE_LENGTH: r_length    <= i_cfg_data[LW-1:0];
                psv_pkg::CFG_SILENCE_LEVEL: r_silence   <= i_cfg_data[psv_pkg::BYTE_W-1:0];
                psv_pkg::CFG_BLOCK_LENGTH:  r_block_len <= i_cfg_data[psv_pkg::BLKCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Block length clamped to the range 1 to MAX_BLOCK, and the next block phase.
    always_comb begin
        blen_ext = BL_W'(r_block_len);
        if (blen_ext == '0) begin
            blen_eff = BL_W'(1);
        end else if (blen_ext > BL_W'(MAX_BLOCK)) begin
            blen_eff = BL_W'(MAX_BLOCK);
        end else begin
            blen_eff = blen_ext;
        end
        phase_inc  = BL_W'(r_phase) + BL_W'(1);
        phase_next = (phase_inc >= blen_eff) ? '0 : phase_inc[PH_W-1:0];
    end

    // End of data is only acted on at a block start; the position then rewinds.
    always_comb begin
        at_end    = (r_phase == '0) && !(r_pos < r_length);
        stop_now  = at_end && !r_loop;
        pos1      = at_end ? '0 : r_pos;
        addr1     = at_end ? '0 : r_rd_addr;
        have_data = pos1 < r_length;
        addr_inc  = (addr1 == AW'(SAMPLE_DEPTH - 1)) ? '0 : addr1 + AW'(1);
        rd_en     = in_accept && (cmd == psv_pkg::CMD_TICK) &&
                    (r_mode == psv_pkg::MODE_PLAYING) && !stop_now && have_data;
        fwd_hit   = r_w_valid && (w_addr == addr1);
    end

    // Next voice state.
    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_rd_addr = r_rd_addr;
        n_phase   = r_phase;
        if (in_accept) begin
            unique case (cmd)
                psv_pkg::CMD_TICK: begin
                    if (r_mode == psv_pkg::MODE_PLAYING) begin
                        if (stop_now) begin
                            n_mode    = psv_pkg::MODE_STOPPED;
                            n_pos     = '0;
                            n_rd_addr = '0;
                        end else begin
                            if (have_data) begin
                                n_pos     = pos1 + LW'(1);
                                n_rd_addr = addr_inc;
                            end else begin
                                n_pos     = pos1;
                                n_rd_addr = addr1;
                            end
                            n_phase = phase_next;
                        end
                    end
                end
                psv_pkg::CMD_PLAY: begin
                    n_mode    = psv_pkg::MODE_PLAYING;
                    n_pos     = '0;
                    n_rd_addr = '0;
                    n_phase   = '0;
                end
                psv_pkg::CMD_PAUSE: begin
                    if (r_mode == psv_pkg::MODE_PLAYING) begin
                        n_mode = psv_pkg::MODE_PAUSED;
                    end
                end
                psv_pkg::CMD_RESUME: begin
                    if (r_mode == psv_pkg::MODE_PAUSED) begin
                        n_mode = psv_pkg::MODE_PLAYING;
                    end
                end
                psv_pkg::CMD_STOP: begin
                    n_mode    = psv_pkg::MODE_STOPPED;
                    n_pos     = '0;
                    n_rd_addr = '0;
                    n_phase   = '0;
                end
                default: ;
            endcase
        end
    end

    // Result fields of the item being accepted, apart from the scaled byte.
    always_comb begin
        res_base   = '0;
        res_svalid = 1'b0;
        res_end    = 1'b0;
        res_play   = 1'b0;
        if (cmd == psv_pkg::CMD_TICK) begin
            res_base   = r_silence;
            res_svalid = 1'b1;
            if (r_mode == psv_pkg::MODE_PLAYING) begin
                res_end  = stop_now;
                res_play = !stop_now && have_data;
            end
        end
    end

    // Voice state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= psv_pkg::MODE_STOPPED;
            r_pos     <= '0;
            r_rd_addr <= '0;
            r_phase   <= '0;
        end else begin
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_rd_addr <= n_rd_addr;
            r_phase   <= n_phase;
        end
    end

    // A sample write is held in a register while its address is reduced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else begin
            r_w_valid <= in_accept && (cmd == psv_pkg::CMD_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (cmd == psv_pkg::CMD_WRITE)) begin
            r_w_addr_raw <= i_write_addr;
            r_w_byte     <= i_write_byte;
        end
    end

    // Write address modulo the memory depth.
    generate
        if (SAMPLE_DEPTH >= (1 << psv_pkg::WADDR_W)) begin : g_wa_wide
            assign w_addr = AW'(r_w_addr_raw);
        end else if ((1 << AW) == SAMPLE_DEPTH) begin : g_wa_pow2
            assign w_addr = r_w_addr_raw[AW-1:0];
        end else begin : g_wa_recip
            // Quotient by a reciprocal multiply at acceptance, remainder from the registered quotient.
            localparam int unsigned SH = psv_pkg::WADDR_W + AW;
            localparam longint unsigned RECIP =
                ((64'd1 << SH) + longint'(SAMPLE_DEPTH) - 64'd1) / longint'(SAMPLE_DEPTH);
            localparam logic [16:0] RECIP17 = 17'(RECIP);
            localparam logic [psv_pkg::WADDR_W-1:0] DEPTH16 =
                psv_pkg::WADDR_W'(SAMPLE_DEPTH);
            logic [32:0]                 quot_prod;
            logic [psv_pkg::WADDR_W-1:0] r_w_quot;
            logic [31:0]                 quot_back;
            logic [psv_pkg::WADDR_W-1:0] w_rem;

            assign quot_prod = 33'(i_write_addr) * 33'(RECIP17);
            always_ff @(posedge i_clk) begin
                if (in_accept && (cmd == psv_pkg::CMD_WRITE)) begin
                    r_w_quot <= psv_pkg::WADDR_W'(quot_prod >> SH);
                end
            end
            assign quot_back = 32'(r_w_quot) * 32'(DEPTH16);
            assign w_rem     = r_w_addr_raw - quot_back[psv_pkg::WADDR_W-1:0];
            assign w_addr    = w_rem[AW-1:0];
        end
    endgenerate

    // Sample memory.
    psv_ram #(
        .WIDTH (psv_pkg::BYTE_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (r_w_valid),
        .i_waddr (w_addr),
        .i_wdata (r_w_byte),
        .i_re    (rd_en),
        .i_raddr (addr1),
        .o_rdata (ram_q)
    );

    // Stage A: control of the item whose RAM read is under way.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (advance) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_play     <= res_play;
            r_a_fwd      <= fwd_hit;
            r_a_fwd_byte <= r_w_byte;
            r_a_base     <= res_base;
            r_a_svalid   <= res_svalid;
            r_a_mode     <= n_mode;
            r_a_end      <= res_end;
        end
    end

    // Scale: 128 + floor((s - 128) * (volume >> 8) / 256), modulo 256.
    always_comb begin
        smp_byte = r_a_fwd ? r_a_fwd_byte : ram_q;
        smp_diff = $signed({2'b00, smp_byte}) - $signed(10'(psv_pkg::MID_CODE));
        vol_gain = $signed({1'b0, r_volume[psv_pkg::VOL_W-1:8]});
        product  = smp_diff * vol_gain;
        scaled   = product[15:8] ^ psv_pkg::MID_CODE;
    end

    // Stage B: result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (advance) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_a_valid) begin
            r_b_sample <= r_a_play ? scaled : r_a_base;
            r_b_svalid <= r_a_svalid;
            r_b_mode   <= r_a_mode;
            r_b_end    <= r_a_end;
        end
    end

    assign o_valid        = r_b_valid;
    assign o_sample_out   = r_b_sample;
    assign o_sample_valid = r_b_svalid;
    assign o_voice_state  = r_b_mode;
    assign o_end_event    = r_b_end;

endmodule

`default_nettype wire
